// ===== src/rmsb_pkg.sv =====
// rmsb_pkg: shared widths, constants and types of the rms meter
// used by every module of the block; no dependencies
package rmsb_pkg;

  // field and state widths
  localparam int COUNT_W   = 13;
  localparam int SUM_W     = 32;
  localparam int RMS_W     = 16;
  localparam int MV_W      = 13;
  localparam int FRAC_BITS = 6;

  // block length limit and default parameter values
  localparam int MAX_BLOCK           = 4096;
  localparam int DEF_SAMPLE_BITS     = 10;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd100;

  // millivolt scaling: full scale code 1023 is 5000 mV, squared for the mean square
  localparam int MV_NUM_W = 25;
  localparam int MV_DEN_W = 21;
  localparam logic [MV_NUM_W-1:0] MV_NUM = 25'd25000000;
  localparam logic [MV_DEN_W-1:0] MV_DEN = 21'd1046529;

  // iterative unit widths
  localparam int DIV_N_W     = 57;
  localparam int DIV_D_W     = 34;
  localparam int SQRT_IN_W   = 58;
  localparam int SQRT_OUT_W  = SQRT_IN_W / 2;

  // result saturation limits
  localparam logic [RMS_W-1:0] RMS_MAX = '1;
  localparam logic [MV_W-1:0]  MV_MAX  = '1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } block_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QLVL_W-1:0] level;
  } queue_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_DIV1,
    B_SQRT1,
    B_DIV2,
    B_SQRT2,
    B_DONE
  } back_state_t;

endpackage

// ===== src/rmsb_div.sv =====
// rmsb_div: restoring unsigned divider, one quotient bit per cycle
// depends on rmsb_pkg
module rmsb_div
  import rmsb_pkg::*;
#(
  parameter int N_W = DIV_N_W,
  parameter int D_W = DIV_D_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [N_W-1:0]   quo;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             fits;

  always_comb begin
    trial = {rem, quo[N_W-1]};
    fits  = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      quo <= {quo[N_W-2:0], fits};
      rem <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

// ===== src/rmsb_sqrt.sv =====
// rmsb_sqrt: digit-by-digit integer square root, one root bit per cycle
// depends on rmsb_pkg
module rmsb_sqrt
  import rmsb_pkg::*;
#(
  parameter int IN_W = SQRT_IN_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [IN_W-1:0]     radicand,
  output logic                done,
  output logic [IN_W/2-1:0]   root
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;
  localparam int CUR_W = OUT_W + 4;
  localparam int CNT_W = $clog2(OUT_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [IN_W-1:0]  rad;
  logic [REM_W-1:0] rem;
  logic [OUT_W-1:0] res;
  logic [CUR_W-1:0] cur;
  logic [CUR_W-1:0] trial;
  logic [CUR_W-1:0] diff;
  logic             fits;

  always_comb begin
    cur   = {rem, rad[IN_W-1:IN_W-2]};
    trial = {2'b00, res, 2'b01};
    fits  = cur >= trial;
    diff  = cur - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(OUT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      rad <= {rad[IN_W-3:0], 2'b00};
      rem <= fits ? diff[REM_W-1:0] : cur[REM_W-1:0];
      res <= {res[OUT_W-2:0], fits};
    end
  end

  assign root = res;

endmodule

// ===== src/rmsb_fifo.sv =====
// rmsb_fifo: short queue of closed blocks between front and back
// depends on rmsb_pkg
module rmsb_fifo
  import rmsb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  block_t        push_data,
  input  logic          pop,
  output block_t        pop_data,
  output queue_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  block_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [QLVL_W-1:0]  level;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign pop_data     = mem[rd_ptr];
  assign status.level = level;
  assign status.empty = (level == '0);
  assign status.full  = (level == QLVL_W'(QUEUE_DEPTH));

endmodule

// ===== src/rmsb_front.sv =====
// rmsb_front: sample intake, square accumulation and block close detection
// depends on rmsb_pkg; feeds rmsb_fifo
module rmsb_front
  import rmsb_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [COUNT_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  queue_status_t          q_status,
  output logic                   push,
  output block_t                 push_data
);

  logic [COUNT_W-1:0] count_cfg;
  logic [SUM_W-1:0]   square_sum;
  logic [COUNT_W-1:0] samples_seen;

  logic [SUM_W-1:0]   sq;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;
  logic [COUNT_W-1:0] seen_inc;
  logic [COUNT_W-1:0] eff_count;
  logic               accept;
  logic               close;

  always_comb begin
    eff_count = count_cfg;
    if (count_cfg == '0) begin
      eff_count = COUNT_W'(1);
    end else if (32'(count_cfg) > 32'(MAX_BLOCK)) begin
      eff_count = COUNT_W'(MAX_BLOCK);
    end
  end

  always_comb begin
    sq       = SUM_W'(sample) * SUM_W'(sample);
    sum_wide = {1'b0, square_sum} + {1'b0, sq};
    sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    seen_inc = samples_seen + 1'b1;
    close    = (seen_inc >= eff_count);
  end

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && close;

  assign push_data.sum   = sum_sat;
  assign push_data.count = eff_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_cfg <= COUNT_RESET;
    end else if (cfg_we) begin
      count_cfg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      samples_seen <= '0;
    end else if (accept) begin
      if (close) begin
        square_sum   <= '0;
        samples_seen <= '0;
      end else begin
        square_sum   <= sum_sat;
        samples_seen <= seen_inc;
      end
    end
  end

endmodule

// ===== src/rmsb_back.sv =====
// rmsb_back: sequencer that turns a closed block into rms and millivolt results
// depends on rmsb_pkg, rmsb_div and rmsb_sqrt
module rmsb_back
  import rmsb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  block_t           q_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RMS_W-1:0] rms_value,
  output logic [MV_W-1:0]  rms_millivolts
);

  back_state_t state, state_next;

  logic [SUM_W-1:0]      sum_reg;
  logic [COUNT_W-1:0]    cnt_reg;
  logic [DIV_N_W-1:0]    num2;
  logic [DIV_D_W-1:0]    den2;
  logic [RMS_W-1:0]      rms_hold;
  logic [MV_W-1:0]       mv_hold;

  logic                  div_start;
  logic                  div_sel2;
  logic                  div_done;
  logic [DIV_N_W-1:0]    div_n;
  logic [DIV_D_W-1:0]    div_d;
  logic [DIV_N_W-1:0]    div_q;
  logic                  sqrt_start;
  logic                  sqrt_done;
  logic [SQRT_OUT_W-1:0] sqrt_root;
  logic                  cap_rms;
  logic                  cap_mv;
  logic                  out_load;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (q_valid)   state_next = B_LOAD;
      B_LOAD:                 state_next = B_DIV1;
      B_DIV1:  if (div_done)  state_next = B_SQRT1;
      B_SQRT1: if (sqrt_done) state_next = B_DIV2;
      B_DIV2:  if (div_done)  state_next = B_SQRT2;
      B_SQRT2: if (sqrt_done) state_next = B_DONE;
      B_DONE:  if (out_free)  state_next = B_IDLE;
      default:                state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    div_start  = 1'b0;
    div_sel2   = 1'b0;
    sqrt_start = 1'b0;
    cap_rms    = 1'b0;
    cap_mv     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      B_IDLE:  pop = q_valid;
      B_LOAD:  div_start = 1'b1;
      B_DIV1:  sqrt_start = div_done;
      B_SQRT1: begin
        div_sel2  = 1'b1;
        div_start = sqrt_done;
        cap_rms   = sqrt_done;
      end
      B_DIV2:  sqrt_start = div_done;
      B_SQRT2: cap_mv = sqrt_done;
      B_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // first pass divides sum * 4096 by count, second the millivolt mean square
  assign div_n = div_sel2 ? num2 : DIV_N_W'({sum_reg, {(2 * FRAC_BITS){1'b0}}});
  assign div_d = div_sel2 ? den2 : DIV_D_W'(cnt_reg);

  rmsb_div #(
    .N_W (DIV_N_W),
    .D_W (DIV_D_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  rmsb_sqrt #(
    .IN_W (SQRT_IN_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (SQRT_IN_W'(div_q)),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      sum_reg <= q_data.sum;
      cnt_reg <= q_data.count;
    end
    if (state == B_LOAD) begin
      num2 <= DIV_N_W'(sum_reg) * DIV_N_W'(MV_NUM);
      den2 <= DIV_D_W'(cnt_reg) * DIV_D_W'(MV_DEN);
    end
    if (cap_rms) begin
      rms_hold <= (sqrt_root > SQRT_OUT_W'(RMS_MAX)) ? RMS_MAX : sqrt_root[RMS_W-1:0];
    end
    if (cap_mv) begin
      mv_hold <= (sqrt_root > SQRT_OUT_W'(MV_MAX)) ? MV_MAX : sqrt_root[MV_W-1:0];
    end
    if (out_load) begin
      rms_value      <= rms_hold;
      rms_millivolts <= mv_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/rms_of_sample_block.sv =====
// rms_of_sample_block: top level of the rms meter over blocks of samples
// depends on rmsb_pkg, rmsb_front, rmsb_fifo and rmsb_back
// usage
//   input channel: in_valid / in_ready with one unsigned sample per transfer
//   output channel: out_valid / out_ready with rms_value (6 fraction bits,
//     truncated) and rms_millivolts (rms * 5000 / 1023, rounded down)
//   configuration: sample_count is written on any edge with cfg_we high and rst low;
//     0 acts as 1, values above 4096 act as 4096
// throughput
//   the front end takes one sample per cycle while the queue is not full, squaring
//   and accumulating it; a closed block's sum and count go into a two-entry queue
//   the back end finishes one block before it pops the next: two passes of the
//   shared one-bit-per-cycle divider, two passes of the shared square root unit
//   and its sequencing states
// block flow
//   once popped, a block goes through B_LOAD, B_DIV1, B_SQRT1, B_DIV2, B_SQRT2 and
//   B_DONE to out_valid; short blocks fill the queue and in_ready drops until a pop
// reset and stall
//   rst (synchronous) clears accumulator, counter, queue and out_valid and
//   sets sample_count to 100; a stalled receiver holds the result, the back end
//   waits after its current block and the front end runs on until the queue fills
module rms_of_sample_block
  import rmsb_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [COUNT_W-1:0]     sample_count,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [RMS_W-1:0]       rms_value,
  output logic [MV_W-1:0]        rms_millivolts
);

  // queue traffic between the two halves
  logic          q_push;
  logic          q_pop;
  block_t        q_in;
  block_t        q_out;
  queue_status_t q_status;

  // front end: accepts samples and decides where a block closes
  rmsb_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (sample_count),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .q_status  (q_status),
    .push      (q_push),
    .push_data (q_in)
  );

  // closed blocks waiting for the back end
  rmsb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_status)
  );

  // back end: divide, root and output register
  rmsb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (!q_status.empty),
    .q_data         (q_out),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rms_value      (rms_value),
    .rms_millivolts (rms_millivolts)
  );

  // queue never holds more than its depth
  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    q_status.level <= QLVL_W'(QUEUE_DEPTH))
    else $error("block queue level above depth");

  // a block only closes into a queue with room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("block pushed into a full queue");

  // the back end only takes a block that is there
  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("block popped from an empty queue");

  // no result straight after reset
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule
